// ----- hdl/lbp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 LBP stream block.
// No dependencies; used by every module under hdl/.
package lbp_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_W = 11;
	localparam int CTR_W = 10;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam logic [CFG_W-1:0] WIDTH_RST = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

	// configuration register indexes
	localparam logic CFG_IMAGE_WIDTH = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic frame_start;
	} pix_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] lbp_code;
		logic [CTR_W-1:0] center_col;
		logic [CTR_W-1:0] center_row;
		logic frame_last;
	} code_word_t;

	// one window column, top to bottom
	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} column_t;

endpackage

// ----- hdl/lbp_line_buf.sv -----
`timescale 1ns / 1ps
// Two-row line buffer: each entry holds {row two up, row one up} of a column.
// One registered read port, one write port. Depends on lbp_pkg.
module lbp_line_buf #(
	parameter int DEPTH = lbp_pkg::MAX_WIDTH_DEF,
	parameter int AW = $clog2(lbp_pkg::MAX_WIDTH_DEF)
) (
	input  logic clk,
	input  logic rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [2*lbp_pkg::PIX_W-1:0] rd_data,
	input  logic wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [2*lbp_pkg::PIX_W-1:0] wr_data
);
	import lbp_pkg::*;

	logic [2*PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/lbp_win_cell.sv -----
`timescale 1ns / 1ps
// One column cell of the 3x3 window: holds a column, passes it on when the
// window shifts, and compares its pixels against the center. Depends on lbp_pkg.
module lbp_win_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  lbp_pkg::column_t col_in,
	input  lbp_pkg::pixel_t center,
	output lbp_pkg::column_t col_out,
	output logic [2:0] gt
);
	import lbp_pkg::*;

	column_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;
	assign gt = {col_q.top > center, col_q.mid > center, col_q.bot > center};

endmodule

// ----- hdl/lbp_3x3_stream.sv -----
`timescale 1ns / 1ps
// Streaming 3x3 local binary pattern over raster pixels.
// The pixel word that completes a code is registered in stage 1, then the code in the output register.
// One pixel word per clock while pix_stall is low; the line buffer does one read and one write a cycle.
// Reset: counters, window and handshake state clear; line buffer holds garbage until written.
// Depends on lbp_pkg, lbp_line_buf, lbp_win_cell.
module lbp_3x3_stream #(
	parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_stall,
	input  lbp_pkg::pix_word_t pix,
	output logic code_valid,
	input  logic code_stall,
	output lbp_pkg::code_word_t code,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [lbp_pkg::CFG_W-1:0] cfg_data
);
	import lbp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WCMP = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
	localparam int HCMP = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

	// configuration
	logic [CFG_W-1:0] image_width_q, image_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RST;
			image_height_q <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: image_width_q <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped frame size
	logic [WCMP-1:0] wreg, w_eff;
	logic [HCMP-1:0] hreg, h_eff;

	always_comb begin
		wreg = WCMP'(image_width_q);
		hreg = HCMP'(image_height_q);
		if (wreg < WCMP'(3)) begin
			w_eff = WCMP'(3);
		end else if (wreg > WCMP'(MAX_WIDTH)) begin
			w_eff = WCMP'(MAX_WIDTH);
		end else begin
			w_eff = wreg;
		end
		if (hreg < HCMP'(3)) begin
			h_eff = HCMP'(3);
		end else if (hreg > HCMP'(MAX_HEIGHT)) begin
			h_eff = HCMP'(MAX_HEIGHT);
		end else begin
			h_eff = hreg;
		end
	end

	// handshake
	logic acc, s1_adv, out_free;
	logic valid_s1, emit_s1, last_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	pixel_t px_s1;
	logic code_valid_q;
	code_word_t code_q;

	assign out_free = !code_valid_q || !code_stall;
	assign s1_adv = valid_s1 && (!emit_s1 || out_free);
	assign pix_stall = valid_s1 && !s1_adv;
	assign acc = pix_valid && !pix_stall;

	// position of the arriving pixel
	logic [CW-1:0] col_q, col_cur;
	logic [RW-1:0] row_q, row_cur;
	logic col_wrap, row_wrap, last_cur, emit_cur;

	always_comb begin
		col_cur = pix.frame_start ? '0 : col_q;
		row_cur = pix.frame_start ? '0 : row_q;
		col_wrap = (WCMP'(col_cur) + WCMP'(1)) >= w_eff;
		row_wrap = (HCMP'(row_cur) + HCMP'(1)) >= h_eff;
		last_cur = (HCMP'(row_cur) == h_eff - HCMP'(1)) && (WCMP'(col_cur) == w_eff - WCMP'(1));
		emit_cur = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_cur + RW'(1);
			end else begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	// stage 1: line buffer read lands here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1 <= pix.pixel;
			col_s1 <= col_cur;
			row_s1 <= row_cur;
			emit_s1 <= emit_cur;
			last_s1 <= last_cur;
		end
	end

	// line buffer with bypass for a column rewritten on the same edge it is read
	logic [2*PIX_W-1:0] rd_data, wr_data, byp_data_q;
	logic byp_q;
	pixel_t top_eff, mid_eff;

	assign top_eff = byp_q ? byp_data_q[2*PIX_W-1:PIX_W] : rd_data[2*PIX_W-1:PIX_W];
	assign mid_eff = byp_q ? byp_data_q[PIX_W-1:0] : rd_data[PIX_W-1:0];
	assign wr_data = {mid_eff, px_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (acc) begin
			byp_q <= s1_adv && (col_cur == col_s1);
		end else if (s1_adv) begin
			byp_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byp_data_q <= wr_data;
		end
	end

	lbp_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_line_buf (
		.clk(clk),
		.rd_en(acc),
		.rd_addr(col_cur),
		.rd_data(rd_data),
		.wr_en(s1_adv),
		.wr_addr(col_s1),
		.wr_data(wr_data)
	);

	// window: u_cell_one holds the column one back, u_cell_two the column two back
	column_t col_new, col_one, col_two;
	logic [2:0] gt_one, gt_two;
	pixel_t center;

	assign col_new = '{top: top_eff, mid: mid_eff, bot: px_s1};
	assign center = col_one.mid;

	lbp_win_cell u_cell_one (
		.clk(clk),
		.arst_n(arst_n),
		.shift(s1_adv),
		.col_in(col_new),
		.center(center),
		.col_out(col_one),
		.gt(gt_one)
	);

	lbp_win_cell u_cell_two (
		.clk(clk),
		.arst_n(arst_n),
		.shift(s1_adv),
		.col_in(col_one),
		.center(center),
		.col_out(col_two),
		.gt(gt_two)
	);

	// output register
	code_word_t code_d;
	logic [31:0] ccol_full, crow_full;

	always_comb begin
		ccol_full = 32'(col_s1) - 32'd1;
		crow_full = 32'(row_s1) - 32'd1;
		// clockwise from top-left
		code_d.lbp_code = {gt_two[2], gt_one[2], top_eff > center, mid_eff > center,
			px_s1 > center, gt_one[0], gt_two[0], gt_two[1]};
		code_d.center_col = ccol_full[CTR_W-1:0];
		code_d.center_row = crow_full[CTR_W-1:0];
		code_d.frame_last = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			code_valid_q <= 1'b1;
		end else if (!code_stall) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			code_q <= code_d;
		end
	end

	assign code_valid = code_valid_q;
	assign code = code_q;

	// checks
	a_byp_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		byp_q |-> valid_s1)
		else $error("bypass flagged with no word in stage 1");

	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && emit_s1 && s1_adv) |=> code_valid)
		else $error("emitted code did not reach the output register");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pix.frame_start) |=> (valid_s1 && col_s1 == '0 && row_s1 == '0))
		else $error("frame start did not restart the position");

endmodule

// ----- verif/lbp_code_checker.sv -----
`timescale 1ns / 1ps
// Checker for lbp_3x3_stream: watches the pixel, code and config channels,
// predicts every code word from accepted pixel words and compares in order.
// Depends on lbp_pkg only.
module lbp_code_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	input  logic pix_stall,
	input  lbp_pkg::pix_word_t pix,
	input  logic code_valid,
	input  logic code_stall,
	input  lbp_pkg::code_word_t code,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic cfg_index,
	input  logic [lbp_pkg::CFG_W-1:0] cfg_data,
	output int err_count,
	output int pending,
	output int codes_checked
);
	import lbp_pkg::*;

	localparam int LINE_LEN = MAX_WIDTH_DEF;

	// never-written entries read as zero here; stimulus keeps them out of codes
	pixel_t upper_line [LINE_LEN] = '{default: '0};
	pixel_t middle_line [LINE_LEN] = '{default: '0};
	column_t left_col, ctr_col;
	int col_pos, row_pos;
	logic [CFG_W-1:0] width_reg, height_reg;
	code_word_t expected_codes [$];

	function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int wd, ht, idx;
		pixel_t top, mid, c;
		code_word_t cw, want;
		if (!arst_n) begin
			expected_codes.delete();
			left_col = '0;
			ctr_col = '0;
			col_pos = 0;
			row_pos = 0;
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			err_count = 0;
			codes_checked = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_IMAGE_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end

			if (pix_valid && !pix_stall) begin
				wd = clamp_dim(width_reg, MAX_WIDTH_DEF);
				ht = clamp_dim(height_reg, MAX_HEIGHT_DEF);
				if (pix.frame_start) begin
					col_pos = 0;
					row_pos = 0;
				end
				idx = col_pos % LINE_LEN;
				top = upper_line[idx];
				mid = middle_line[idx];
				upper_line[idx] = mid;
				middle_line[idx] = pix.pixel;
				if (row_pos >= 2 && col_pos >= 2) begin
					// center is (row-1, col-1); right column is top/mid/arriving pixel
					c = ctr_col.mid;
					cw.lbp_code = {left_col.top > c, ctr_col.top > c, top > c, mid > c,
						pix.pixel > c, ctr_col.bot > c, left_col.bot > c, left_col.mid > c};
					cw.center_col = CTR_W'(col_pos - 1);
					cw.center_row = CTR_W'(row_pos - 1);
					cw.frame_last = (row_pos == ht - 1) && (col_pos == wd - 1);
					expected_codes = {expected_codes, cw};
				end
				left_col = ctr_col;
				ctr_col.top = top;
				ctr_col.mid = mid;
				ctr_col.bot = pix.pixel;
				// a column at or past a shrunk width also ends the row
				if (col_pos + 1 >= wd) begin
					col_pos = 0;
					row_pos = (row_pos + 1 >= ht) ? 0 : row_pos + 1;
				end else begin
					col_pos++;
				end
			end

			if (code_valid && !code_stall) begin
				if (expected_codes.size() == 0) begin
					err_count++;
					$display("%0t ns: unexpected code word: expected none, actual %h",
						$time, code);
				end else begin
					want = expected_codes.pop_front();
					codes_checked++;
					if (code.lbp_code !== want.lbp_code || code.center_col !== want.center_col
							|| code.center_row !== want.center_row
							|| code.frame_last !== want.frame_last) begin
						err_count++;
						$display("%0t ns: code word mismatch: expected code %h col %0d row %0d last %0d",
							$time, want.lbp_code, want.center_col, want.center_row,
							want.frame_last);
						$display("%0t ns:   actual code %h col %0d row %0d last %0d",
							$time, code.lbp_code, code.center_col, code.center_row,
							code.frame_last);
					end
				end
			end
			pending = expected_codes.size();
		end
	end

endmodule

// ----- verif/tb_lbp_3x3_stream.sv -----
`timescale 1ns / 1ps
// Top of the lbp_3x3_stream testbench: clock, reset, pixel and config stimulus,
// code-side stalls and the verdict. Depends on lbp_pkg, lbp_code_checker and the block.
module tb_lbp_3x3_stream;
	import lbp_pkg::*;

	localparam int RANDOM_PIXELS = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 4_000_000;

	// probe frames: center 0 ringed by 255, a wrapped partial frame, then a
	// restart in mid frame followed by a frame full of equal neighbors
	localparam int PROBE_LEN = 22;
	localparam logic [0:PROBE_LEN-1][7:0] PROBE_PX = {
		8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
		8'h55, 8'haa, 8'h55, 8'haa,
		8'h80, 8'h81, 8'h7f, 8'h7f, 8'h80, 8'h80, 8'h80, 8'h81, 8'h80};
	localparam logic [0:PROBE_LEN-1] PROBE_FS = 22'b1000000000000100000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_word_t pix = '0;
	logic code_valid;
	logic code_stall = 1'b0;
	code_word_t code;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	int err_count, pending, codes_checked;
	int cycle_cnt = 0;
	int pixels_sent = 0;
	int reg_writes = 0;
	int stall_hold = 0;
	int cur_w, cur_h;
	int pix_mode = 0;
	int pix_base = 0;
	bit quiet = 1'b0;

	always #5 clk = ~clk;

	lbp_3x3_stream dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lbp_code_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.err_count(err_count),
		.pending(pending),
		.codes_checked(codes_checked)
	);

	// mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(15, 30);
	endfunction

	function automatic int pixel_gap();
		if (quiet || $urandom_range(0, 99) < 55)
			return 0;
		return idle_len();
	endfunction

	function automatic pixel_t next_pixel();
		case (pix_mode)
			0: return pixel_t'($urandom_range(0, 255));
			// narrow band: lots of equal neighbors
			1: return pixel_t'(pix_base + $urandom_range(0, 2));
			default: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
		endcase
	endfunction

	function automatic int clamp_dim(int v);
		if (v < 3)
			return 3;
		if (v > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return v;
	endfunction

	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (quiet) begin
			code_stall <= 1'b0;
		end else begin
			code_stall <= ($urandom_range(0, 99) < 35);
			stall_hold <= idle_len() - 1;
		end
	end

	task automatic write_reg(input logic idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	task automatic send_pixel(input pixel_t v, input logic fs);
		int gap;
		pix_word_t w;
		gap = pixel_gap();
		w.pixel = v;
		w.frame_start = fs;
		@(negedge clk);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pix <= w;
		do @(posedge clk); while (pix_stall);
		pixels_sent++;
	endtask

	task automatic run_frames(input int count, input bit restart, input int noise_pct);
		for (int i = 0; i < count; i++)
			send_pixel(next_pixel(), (i == 0) ? restart : ($urandom_range(0, 99) < noise_pct));
	endtask

	// block goes idle: no code owed, and the pipeline has flushed border words
	task automatic drain();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d code words still owed", cycle_cnt, pending);
		$display("tb_lbp_3x3_stream failed");
		$finish;
	end

	initial begin : stimulus
		int w_val, h_val, new_w, count, sel;
		bit restart;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// both sizes below the minimum: clamp to 3x3
		write_reg(CFG_IMAGE_WIDTH, 0);
		write_reg(CFG_IMAGE_HEIGHT, 2);
		cur_w = 3;
		cur_h = 3;
		for (int i = 0; i < PROBE_LEN; i++)
			send_pixel(PROBE_PX[i], PROBE_FS[i]);
		drain();

		while (pixels_sent < PROBE_LEN + RANDOM_PIXELS) begin
			quiet = ($urandom_range(0, 4) == 0);
			pix_mode = $urandom_range(0, 2);
			pix_base = $urandom_range(0, 253);
			sel = $urandom_range(0, 9);
			restart = ($urandom_range(0, 2) == 0);
			if (sel < 7) begin
				w_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
				h_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
				write_reg(CFG_IMAGE_WIDTH, w_val);
				write_reg(CFG_IMAGE_HEIGHT, h_val);
				new_w = clamp_dim(w_val);
				// a wider row would pull line entries never written into codes
				if (new_w > cur_w)
					restart = 1'b1;
				cur_w = new_w;
				cur_h = clamp_dim(h_val);
			end
			// a whole frame plus a tail, so a phase may end mid frame
			count = cur_w * cur_h + $urandom_range(0, cur_w * cur_h - 1);
			run_frames(count, restart, (sel == 9) ? 4 : 0);
			drain();
		end

		// width clamped from above: two full-width rows, then codes on the third
		quiet = 1'b0;
		pix_mode = 0;
		write_reg(CFG_IMAGE_WIDTH, 2047);
		write_reg(CFG_IMAGE_HEIGHT, 0);
		run_frames(2 * MAX_WIDTH_DEF + 6, 1'b1, 0);
		drain();

		$display("run covered %0d pixel words, %0d code words checked, %0d register writes",
			pixels_sent, codes_checked, reg_writes);
		$display("frame widths went from the clamped minimum of 3 up to the clamped 1024");
		if (err_count == 0 && pending == 0)
			$display("tb_lbp_3x3_stream passed");
		else
			$display("tb_lbp_3x3_stream failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/lbp_pkg.sv
hdl/lbp_line_buf.sv
hdl/lbp_win_cell.sv
hdl/lbp_3x3_stream.sv
verif/lbp_code_checker.sv
verif/tb_lbp_3x3_stream.sv
